### hdl/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg: shared types and constants of the Lua string and comment scanner
// Scanner modes, class codes, result codes, burst descriptor and characters.
// ----------------------------------------------------------------------------
package lsc_pkg;

    localparam int MAX_LEVEL_DEFAULT   = 14;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_EQUALS   = 8'h3D;
    localparam logic [7:0] CH_DASH     = 8'h2D;
    localparam logic [7:0] CH_DQUOTE   = 8'h22;
    localparam logic [7:0] CH_SQUOTE   = 8'h27;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_NONE     = 8'h00;

    typedef enum logic [3:0] {
        MODE_NORMAL       = 4'd0,
        MODE_DASH         = 4'd1,
        MODE_BRACKET      = 4'd2,
        MODE_QUOTE        = 4'd3,
        MODE_DASHDASH     = 4'd4,
        MODE_CBRACKET     = 4'd5,
        MODE_LINE_COMMENT = 4'd6,
        MODE_LONG_COMMENT = 4'd7,
        MODE_LONG_STRING  = 4'd8
    } mode_t;

    typedef enum logic [1:0] {
        CLS_CODE    = 2'd0,
        CLS_STRING  = 2'd1,
        CLS_COMMENT = 2'd2
    } class_t;

    typedef enum logic [1:0] {
        OPEN_NONE    = 2'd0,
        OPEN_COMMENT = 2'd1,
        OPEN_STRING  = 2'd2
    } open_t;

    typedef enum logic {
        CMD_CHAR = 1'b0,
        CMD_EOL  = 1'b1
    } cmd_t;

    typedef enum logic {
        RES_CHAR = 1'b0,
        RES_LINE = 1'b1
    } res_kind_t;

    // Prefix of a burst: bytes held back earlier and released by this item
    typedef enum logic [2:0] {
        PRE_NONE      = 3'd0,
        PRE_DASH_CODE = 3'd1,
        PRE_DASH_PAIR = 3'd2,
        PRE_OPEN_CODE = 3'd3,
        PRE_OPEN_STR  = 3'd4
    } pre_t;

    // One queued burst; the '=' count of an opener travels beside it
    typedef struct packed {
        pre_t       pre;
        logic       tail_en;
        res_kind_t  tail_kind;
        logic [7:0] tail_ch;
        class_t     tail_cls;
        open_t      tail_open;
        logic [3:0] tail_lvl;
    } desc_t;

    // Outcome of scanning one byte in normal code mode
    typedef struct packed {
        logic   emit;
        class_t cls;
        mode_t  mode;
        logic   set_quote;
        logic   quote_dbl;
        logic   clr_oe;
    } norm_t;

endpackage

### hdl/lsc_front.sv
// ----------------------------------------------------------------------------
// lsc_front: scanner state and item classification
// Tracks the Lua lexer mode and turns each item into one burst descriptor.
// ----------------------------------------------------------------------------
module lsc_front
    import lsc_pkg::*;
#(
    parameter int MAX_LEVEL = MAX_LEVEL_DEFAULT,
    localparam int LW = $clog2(MAX_LEVEL + 2)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          cmd,
    input  logic [7:0]    char_code,
    input  logic          q_ready,
    output logic          push,
    output desc_t         desc,
    output logic [LW-1:0] eq_count
);

    mode_t         mode_reg, mode_next;
    logic          quote_dbl_reg, quote_dbl_next;
    logic          esc_reg, esc_next;
    logic [LW-1:0] oe_reg, oe_next;
    logic [LW-1:0] level_reg, level_next;
    logic [LW-1:0] ce_reg, ce_next;
    logic          armed_reg, armed_next;
    logic          accept;
    logic          desc_nonempty;
    norm_t         norm;

    function automatic norm_t scan_normal(input logic [7:0] ch);
        norm_t r;
        r = '{emit: 1'b1, cls: CLS_CODE, mode: MODE_NORMAL,
              set_quote: 1'b0, quote_dbl: 1'b0, clr_oe: 1'b0};
        if (ch == CH_SQUOTE || ch == CH_DQUOTE)
        begin
            r.cls       = CLS_STRING;
            r.mode      = MODE_QUOTE;
            r.set_quote = 1'b1;
            r.quote_dbl = (ch == CH_DQUOTE);
        end
        else if (ch == CH_DASH)
        begin
            r.emit = 1'b0;
            r.mode = MODE_DASH;
        end
        else if (ch == CH_LBRACKET)
        begin
            r.emit   = 1'b0;
            r.mode   = MODE_BRACKET;
            r.clr_oe = 1'b1;
        end
        return r;
    endfunction

    assign norm     = scan_normal(char_code);
    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;

    // Next state
    always_comb
    begin
        mode_next      = mode_reg;
        quote_dbl_next = quote_dbl_reg;
        esc_next       = esc_reg;
        oe_next        = oe_reg;
        level_next     = level_reg;
        ce_next        = ce_reg;
        armed_next     = armed_reg;
        if (cmd == CMD_EOL)
        begin
            if (mode_reg != MODE_LONG_COMMENT && mode_reg != MODE_LONG_STRING)
            begin
                mode_next = MODE_NORMAL;
            end
            esc_next   = 1'b0;
            oe_next    = '0;
            ce_next    = '0;
            armed_next = 1'b0;
        end
        else
        begin
            case (mode_reg)
                MODE_DASH:
                begin
                    if (char_code == CH_DASH)
                    begin
                        mode_next = MODE_DASHDASH;
                    end
                    else
                    begin
                        mode_next = norm.mode;
                        if (norm.set_quote)
                        begin
                            quote_dbl_next = norm.quote_dbl;
                            esc_next       = 1'b0;
                        end
                        if (norm.clr_oe)
                        begin
                            oe_next = '0;
                        end
                    end
                end
                MODE_BRACKET:
                begin
                    if (char_code == CH_EQUALS && oe_reg < LW'(MAX_LEVEL))
                    begin
                        oe_next = oe_reg + LW'(1);
                    end
                    else if (char_code == CH_LBRACKET)
                    begin
                        mode_next  = MODE_LONG_STRING;
                        level_next = oe_reg;
                        armed_next = 1'b0;
                        ce_next    = '0;
                        oe_next    = '0;
                    end
                    else
                    begin
                        oe_next   = '0;
                        mode_next = norm.mode;
                        if (norm.set_quote)
                        begin
                            quote_dbl_next = norm.quote_dbl;
                            esc_next       = 1'b0;
                        end
                    end
                end
                MODE_QUOTE:
                begin
                    if (char_code == (quote_dbl_reg ? CH_DQUOTE : CH_SQUOTE) && !esc_reg)
                    begin
                        mode_next = MODE_NORMAL;
                        esc_next  = 1'b0;
                    end
                    else
                    begin
                        esc_next = (char_code == CH_BSLASH) && !esc_reg;
                    end
                end
                MODE_DASHDASH:
                begin
                    if (char_code == CH_LBRACKET)
                    begin
                        oe_next   = '0;
                        mode_next = MODE_CBRACKET;
                    end
                    else
                    begin
                        mode_next = MODE_LINE_COMMENT;
                    end
                end
                MODE_CBRACKET:
                begin
                    if (char_code == CH_EQUALS && oe_reg < LW'(MAX_LEVEL))
                    begin
                        oe_next = oe_reg + LW'(1);
                    end
                    else if (char_code == CH_LBRACKET)
                    begin
                        mode_next  = MODE_LONG_COMMENT;
                        level_next = oe_reg;
                        armed_next = 1'b0;
                        ce_next    = '0;
                        oe_next    = '0;
                    end
                    else
                    begin
                        oe_next   = '0;
                        mode_next = MODE_LINE_COMMENT;
                    end
                end
                MODE_LINE_COMMENT:
                begin
                    mode_next = MODE_LINE_COMMENT;
                end
                MODE_LONG_COMMENT, MODE_LONG_STRING:
                begin
                    if (char_code == CH_RBRACKET)
                    begin
                        ce_next = '0;
                        if (armed_reg && ce_reg == level_reg)
                        begin
                            armed_next = 1'b0;
                            mode_next  = MODE_NORMAL;
                        end
                        else
                        begin
                            armed_next = 1'b1;
                        end
                    end
                    else if (char_code == CH_EQUALS && armed_reg)
                    begin
                        // saturate one above the deepest level: never matches
                        if (ce_reg <= LW'(MAX_LEVEL))
                        begin
                            ce_next = ce_reg + LW'(1);
                        end
                    end
                    else
                    begin
                        armed_next = 1'b0;
                        ce_next    = '0;
                    end
                end
                default:
                begin
                    mode_next = norm.mode;
                    if (norm.set_quote)
                    begin
                        quote_dbl_next = norm.quote_dbl;
                        esc_next       = 1'b0;
                    end
                    if (norm.clr_oe)
                    begin
                        oe_next = '0;
                    end
                end
            endcase
        end
    end

    // Burst descriptor for the current item
    always_comb
    begin
        desc = '{pre: PRE_NONE, tail_en: 1'b0, tail_kind: RES_CHAR, tail_ch: char_code,
                 tail_cls: CLS_CODE, tail_open: OPEN_NONE, tail_lvl: 4'd0};
        eq_count = oe_reg;
        if (cmd == CMD_EOL)
        begin
            if (mode_reg == MODE_DASH)
            begin
                desc.pre = PRE_DASH_CODE;
            end
            else if (mode_reg == MODE_BRACKET)
            begin
                desc.pre = PRE_OPEN_CODE;
            end
            desc.tail_en   = 1'b1;
            desc.tail_kind = RES_LINE;
            desc.tail_ch   = CH_NONE;
            if (mode_reg == MODE_LONG_COMMENT)
            begin
                desc.tail_open = OPEN_COMMENT;
                desc.tail_lvl  = 4'(level_reg);
            end
            else if (mode_reg == MODE_LONG_STRING)
            begin
                desc.tail_open = OPEN_STRING;
                desc.tail_lvl  = 4'(level_reg);
            end
        end
        else
        begin
            case (mode_reg)
                MODE_DASH:
                begin
                    if (char_code == CH_DASH)
                    begin
                        desc.pre = PRE_DASH_PAIR;
                    end
                    else
                    begin
                        desc.pre      = PRE_DASH_CODE;
                        desc.tail_en  = norm.emit;
                        desc.tail_cls = norm.cls;
                    end
                end
                MODE_BRACKET:
                begin
                    if (char_code == CH_EQUALS && oe_reg < LW'(MAX_LEVEL))
                    begin
                        desc.pre = PRE_NONE;
                    end
                    else if (char_code == CH_LBRACKET)
                    begin
                        desc.pre = PRE_OPEN_STR;
                    end
                    else
                    begin
                        desc.pre      = PRE_OPEN_CODE;
                        desc.tail_en  = norm.emit;
                        desc.tail_cls = norm.cls;
                    end
                end
                MODE_QUOTE:
                begin
                    desc.tail_en  = 1'b1;
                    desc.tail_cls = CLS_STRING;
                end
                MODE_DASHDASH, MODE_CBRACKET, MODE_LINE_COMMENT, MODE_LONG_COMMENT:
                begin
                    desc.tail_en  = 1'b1;
                    desc.tail_cls = CLS_COMMENT;
                end
                MODE_LONG_STRING:
                begin
                    desc.tail_en  = 1'b1;
                    desc.tail_cls = CLS_STRING;
                end
                default:
                begin
                    desc.tail_en  = norm.emit;
                    desc.tail_cls = norm.cls;
                end
            endcase
        end
    end

    assign desc_nonempty = (desc.pre != PRE_NONE) || desc.tail_en;
    assign push          = accept && desc_nonempty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_NORMAL;
            quote_dbl_reg <= 1'b0;
            esc_reg       <= 1'b0;
            oe_reg        <= '0;
            level_reg     <= '0;
            ce_reg        <= '0;
            armed_reg     <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg      <= mode_next;
            quote_dbl_reg <= quote_dbl_next;
            esc_reg       <= esc_next;
            oe_reg        <= oe_next;
            level_reg     <= level_next;
            ce_reg        <= ce_next;
            armed_reg     <= armed_next;
        end
    end

endmodule

### hdl/lsc_queue.sv
// ----------------------------------------------------------------------------
// lsc_queue: short descriptor queue between scanner and expander
// Register-based ring buffer; head is read at the read pointer.
// ----------------------------------------------------------------------------
module lsc_queue
    import lsc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT,
    parameter int WIDTH = 8,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             ready,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             valid
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign ready = (count_reg != CW'(DEPTH));
    assign valid = (count_reg != '0);
    assign rdata = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ready)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("queue read while empty");

endmodule

### hdl/lsc_back.sv
// ----------------------------------------------------------------------------
// lsc_back: burst expander and output register
// Walks a descriptor into the output stage, a result per cycle unless stalled.
// ----------------------------------------------------------------------------
module lsc_back
    import lsc_pkg::*;
#(
    parameter int MAX_LEVEL = MAX_LEVEL_DEFAULT,
    localparam int LW = $clog2(MAX_LEVEL + 2)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  desc_t         q_desc,
    input  logic [LW-1:0] q_eq,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          result_kind,
    output logic [7:0]    out_char,
    output logic [1:0]    char_class,
    output logic [1:0]    open_kind,
    output logic [3:0]    open_level,
    output logic          last
);

    logic          out_valid_reg;
    logic [LW-1:0] idx_reg, idx_next;
    logic [LW:0]   pre_len;
    logic [LW:0]   total;
    logic [LW-1:0] last_idx;
    logic          is_last;
    logic          in_tail;
    logic          load;
    res_kind_t     kind_cur;
    logic [7:0]    ch_cur;
    class_t        cls_cur;
    open_t         open_cur;
    logic [3:0]    lvl_cur;
    res_kind_t     kind_reg;
    logic [7:0]    ch_reg;
    class_t        cls_reg;
    open_t         open_reg;
    logic [3:0]    lvl_reg;
    logic          last_reg;

    // Burst length: held-back prefix, then the optional tail result
    always_comb
    begin
        case (q_desc.pre)
            PRE_NONE:      pre_len = '0;
            PRE_DASH_CODE: pre_len = (LW + 1)'(1);
            PRE_DASH_PAIR: pre_len = (LW + 1)'(2);
            PRE_OPEN_CODE: pre_len = {1'b0, q_eq} + (LW + 1)'(1);
            PRE_OPEN_STR:  pre_len = {1'b0, q_eq} + (LW + 1)'(2);
            default:       pre_len = '0;
        endcase
    end

    assign total    = pre_len + (LW + 1)'(q_desc.tail_en);
    assign last_idx = LW'(total - (LW + 1)'(1));
    assign is_last  = (idx_reg == last_idx);
    assign in_tail  = ({1'b0, idx_reg} >= pre_len);
    assign load     = !out_valid_reg || out_ready;
    assign q_pop    = load && q_valid && is_last;

    // Result at the current burst position
    always_comb
    begin
        kind_cur = RES_CHAR;
        ch_cur   = CH_EQUALS;
        cls_cur  = CLS_CODE;
        open_cur = OPEN_NONE;
        lvl_cur  = 4'd0;
        if (in_tail)
        begin
            kind_cur = q_desc.tail_kind;
            ch_cur   = q_desc.tail_ch;
            if (q_desc.tail_kind == RES_LINE)
            begin
                open_cur = q_desc.tail_open;
                lvl_cur  = q_desc.tail_lvl;
            end
            else
            begin
                cls_cur = q_desc.tail_cls;
            end
        end
        else
        begin
            case (q_desc.pre)
                PRE_DASH_CODE:
                begin
                    ch_cur = CH_DASH;
                end
                PRE_DASH_PAIR:
                begin
                    ch_cur  = CH_DASH;
                    cls_cur = CLS_COMMENT;
                end
                PRE_OPEN_CODE:
                begin
                    ch_cur = (idx_reg == '0) ? CH_LBRACKET : CH_EQUALS;
                end
                PRE_OPEN_STR:
                begin
                    cls_cur = CLS_STRING;
                    if (idx_reg == '0 || {1'b0, idx_reg} == {1'b0, q_eq} + (LW + 1)'(1))
                    begin
                        ch_cur = CH_LBRACKET;
                    end
                end
                default:
                begin
                    ch_cur = CH_EQUALS;
                end
            endcase
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (load && q_valid)
        begin
            idx_next = is_last ? '0 : idx_reg + LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
            begin
                out_valid_reg <= q_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && q_valid)
        begin
            kind_reg <= kind_cur;
            ch_reg   <= ch_cur;
            cls_reg  <= cls_cur;
            open_reg <= open_cur;
            lvl_reg  <= lvl_cur;
            last_reg <= is_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign out_char    = ch_reg;
    assign char_class  = cls_reg;
    assign open_kind   = open_reg;
    assign open_level  = lvl_reg;
    assign last        = last_reg;

    a_idx_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> (idx_reg <= last_idx))
        else $error("burst position past end of descriptor");

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !q_valid |-> (idx_reg == '0))
        else $error("burst position not cleared while queue empty");

    a_report_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == RES_LINE) |-> last_reg)
        else $error("line end report not flagged as final result");

endmodule

### hdl/lua_string_comment_scanner_core.sv
// ----------------------------------------------------------------------------
// lua_string_comment_scanner_core: Lua string and comment classifier
// Classes each source byte as code, string or comment and reports open
// long brackets at every line end.
// ----------------------------------------------------------------------------
// Feed one byte per item (cmd = 0) and an end-of-line item (cmd = 1) after
// each line. The front scanner takes one item every cycle while the queue has
// room, tracks quotes, escapes, dash-dash comments and long brackets of up to
// MAX_LEVEL '=' signs, and writes one burst descriptor per item that yields
// results. The back expander emits one result per cycle from the queue head
// while out_ready is high. An item yields one result for most bytes, two for
// "--" or a lone dash before a byte, and up to MAX_LEVEL + 2 (16 by default)
// when a long-string opener is released. The sustained rate is therefore one
// item per cycle on ordinary text while out_ready is high, set by the one
// result per cycle of the expander; the QUEUE_DEPTH-entry queue absorbs short
// bursts before in_ready drops. Descriptors are registered in queue slots and
// results in the output register. Bytes that are held back (a dash, or a '['
// opener still being read) produce nothing until the byte that decides them
// arrives; the final result of every item carries last = 1.
// ----------------------------------------------------------------------------
module lua_string_comment_scanner_core
    import lsc_pkg::*;
#(
    parameter int MAX_LEVEL   = MAX_LEVEL_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
    localparam int LW = $clog2(MAX_LEVEL + 2),
    localparam int QW = $bits(desc_t) + LW
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       cmd,
    input  logic [7:0] char_code,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       result_kind,
    output logic [7:0] out_char,
    output logic [1:0] char_class,
    output logic [1:0] open_kind,
    output logic [3:0] open_level,
    output logic       last
);

    // front to queue
    logic          f_push;
    desc_t         f_desc;
    logic [LW-1:0] f_eq;
    logic          q_ready;

    // queue to back
    logic          q_valid;
    logic          q_pop;
    logic [QW-1:0] q_rdata;
    desc_t         h_desc;
    logic [LW-1:0] h_eq;

    // Classify items and hold the lexer mode
    lsc_front #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .char_code (char_code),
        .q_ready   (q_ready),
        .push      (f_push),
        .desc      (f_desc),
        .eq_count  (f_eq)
    );

    // Decouple the scanner from output stalls and bursts
    lsc_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .wdata ({f_desc, f_eq}),
        .ready (q_ready),
        .pop   (q_pop),
        .rdata (q_rdata),
        .valid (q_valid)
    );

    assign {h_desc, h_eq} = q_rdata;

    // Expand each burst into results, one per cycle unless the output stalls
    lsc_back #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_desc      (h_desc),
        .q_eq        (h_eq),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .out_char    (out_char),
        .char_class  (char_class),
        .open_kind   (open_kind),
        .open_level  (open_level),
        .last        (last)
    );

endmodule
